// ===== rtl/core/skf_pkg.sv =====
// Shared types, constants and the microcode table of the scalar Kalman filter core.
// No dependencies; imported by the sequencer, the datapath and the top-level core.
package skf_pkg;

  // Defaults of the top-level parameters
  localparam int SKF_SAMPLE_WIDTH   = 16;
  localparam int SKF_GAIN_FRAC_BITS = 16;

  // Fixed widths of the noise registers and the covariance path
  localparam int REG_W  = 24;          // Q8.16 noise / covariance registers
  localparam int COV_W  = REG_W + 1;   // Q9.16 covariance
  localparam int DEN_W  = COV_W + 1;   // P1 + R
  localparam int REM_W  = DEN_W + 1;   // divider partial remainder
  localparam int CFG_INDEX_W = 2;

  // Register reset values
  localparam logic [REG_W-1:0] PROCESS_NOISE_RST = REG_W'(6554);
  localparam logic [REG_W-1:0] MEASURE_NOISE_RST = REG_W'(65536);
  localparam logic [REG_W-1:0] INIT_COV_RST      = REG_W'(1311);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROCESS_NOISE = 2'd0,
    CFG_MEASURE_NOISE = 2'd1,
    CFG_INIT_COV      = 2'd2
  } cfg_idx_e;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_WAIT = 3'd0,   // take a sample beat
    OP_PREP = 3'd1,   // P1 = P + Q, den = P1 + R, |sample - estimate|
    OP_DIV  = 3'd2,   // one quotient bit of P1 / den
    OP_GSET = 3'd3,   // fix up gain, arm the multipliers
    OP_MUL  = 3'd4,   // one multiplier bit of both products
    OP_FIN1 = 3'd5,   // round both products, update covariance
    OP_FIN2 = 3'd6    // apply correction, saturate, load result beat
  } op_e;

  // Sequencing condition of one microcode step
  typedef enum logic [1:0] {
    C_NEXT = 2'd0,    // fall through
    C_IN   = 2'd1,    // go to target while no sample beat arrives
    C_LOOP = 2'd2,    // go to target while step counter is nonzero
    C_RET  = 2'd3     // go to target once result slot is free, else hold
  } cond_e;

  localparam int UPC_W = 3;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic cnt_zero;
  } status_t;

  localparam logic [UPC_W-1:0] UPC_WAIT = 3'd0;
  localparam logic [UPC_W-1:0] UPC_DIV  = 3'd2;
  localparam logic [UPC_W-1:0] UPC_MUL  = 3'd4;

  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_word_t cw;
    unique case (upc)
      3'd0:    cw = '{op: OP_WAIT, cond: C_IN,   target: UPC_WAIT};
      3'd1:    cw = '{op: OP_PREP, cond: C_NEXT, target: UPC_WAIT};
      3'd2:    cw = '{op: OP_DIV,  cond: C_LOOP, target: UPC_DIV};
      3'd3:    cw = '{op: OP_GSET, cond: C_NEXT, target: UPC_WAIT};
      3'd4:    cw = '{op: OP_MUL,  cond: C_LOOP, target: UPC_MUL};
      3'd5:    cw = '{op: OP_FIN1, cond: C_NEXT, target: UPC_WAIT};
      3'd6:    cw = '{op: OP_FIN2, cond: C_RET,  target: UPC_WAIT};
      default: cw = '{op: OP_WAIT, cond: C_NEXT, target: UPC_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/skf_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on skf_pkg.
module skf_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skf_pkg::status_t status_i,
  output skf_pkg::op_e     op_o
);
  import skf_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_word_t       cw;

  assign cw   = ucode_rom(upc_q);
  assign op_o = cw.op;

  always_comb begin
    upc_d = upc_q + UPC_W'(1);
    unique case (cw.cond)
      C_NEXT: upc_d = upc_q + UPC_W'(1);
      C_IN:   if (!status_i.in_fire) upc_d = cw.target;
      C_LOOP: if (!status_i.cnt_zero) upc_d = cw.target;
      C_RET:  upc_d = status_i.out_free ? cw.target : upc_q;
      default: upc_d = upc_q + UPC_W'(1);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== rtl/core/skf_datapath.sv =====
// Datapath: config registers, filter state, serial divider, dual shift-add
// multiplier, rounding/saturation and the result register. Depends on skf_pkg.
module skf_datapath #(
  parameter int SAMPLE_WIDTH   = skf_pkg::SKF_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = skf_pkg::SKF_GAIN_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skf_pkg::op_e                         op_i,
  output skf_pkg::status_t                     status_o,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]       estimate_o,
  output logic [GAIN_FRAC_BITS:0]              gain_used_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [skf_pkg::REG_W-1:0]            cfg_data_i
);
  import skf_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int GFB   = GAIN_FRAC_BITS;
  localparam int GW    = GFB + 1;
  localparam int DW    = SW + 1;          // |sample - estimate|
  localparam int AW    = DW + GW;         // |d| * G
  localparam int BW    = COV_W + GW;      // P1 * (1 - G)
  localparam int CNT_W = $clog2(GFB + 1);

  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GFB{1'b0}}};
  localparam logic [AW-1:0] HALF_A   = {{(AW-GFB){1'b0}}, 1'b1, {(GFB-1){1'b0}}};
  localparam logic [BW-1:0] HALF_B   = {{(BW-GFB){1'b0}}, 1'b1, {(GFB-1){1'b0}}};
  localparam logic signed [SW+1:0] EST_MAX = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] EST_MIN = {3'b111, {(SW-1){1'b0}}};

  // config and filter state
  logic [REG_W-1:0]     q_noise_q, r_noise_q;
  logic [COV_W-1:0]     cov_q;
  logic signed [SW-1:0] est_q;
  logic [GW-1:0]        gain_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q;

  // working registers
  logic signed [SW-1:0] s_q;
  logic [COV_W-1:0]     p1_q;
  logic [DEN_W-1:0]     den_q;
  logic [DW-1:0]        mag_q;
  logic                 neg_q;
  logic [REM_W-1:0]     rem_q;
  logic [GW-1:0]        quo_q, mg_q, mgc_q;
  logic [AW-1:0]        acc_a_q;
  logic [BW-1:0]        acc_b_q;
  logic [DW-1:0]        rmag_q;
  logic signed [SW-1:0] out_est_q;
  logic [GW-1:0]        out_gain_q;

  logic                 in_fire, out_free;
  logic [DEN_W-1:0]     p1_sum, den;
  logic [COV_W-1:0]     p1;
  logic signed [SW:0]   diff;
  logic [DW-1:0]        mag;
  logic                 ge;
  logic [REM_W-1:0]     rem_sub, rem_next;
  logic [GW-1:0]        g_fix;
  logic [AW-1:0]        acc_a_next, rnd_a;
  logic [BW-1:0]        acc_b_next, rnd_b;
  logic signed [SW+1:0] corr, est_sum;
  logic signed [SW-1:0] est_sat;

  assign in_ready_o  = (op_i == OP_WAIT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign status_o = '{in_fire: in_fire, out_free: out_free, cnt_zero: (cnt_q == '0)};

  // P1 and denominator
  assign p1_sum = {1'b0, cov_q} + {{(DEN_W-REG_W){1'b0}}, q_noise_q};
  assign p1     = p1_sum[COV_W-1:0];
  assign den    = {1'b0, p1} + {{(DEN_W-REG_W){1'b0}}, r_noise_q};

  // innovation magnitude and sign
  assign diff = {s_q[SW-1], s_q} - {est_q[SW-1], est_q};
  assign mag  = diff[SW] ? DW'(-diff) : DW'(diff);

  // restoring divider step
  assign ge       = (rem_q >= {1'b0, den_q});
  assign rem_sub  = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign rem_next = {rem_sub[REM_W-2:0], 1'b0};

  // zero denominator gives zero gain; clamp to one
  always_comb begin
    if (den_q == '0) begin
      g_fix = '0;
    end else if (quo_q > GAIN_ONE) begin
      g_fix = GAIN_ONE;
    end else begin
      g_fix = quo_q;
    end
  end

  // MSB-first shift-add, both products in lockstep
  assign acc_a_next = {acc_a_q[AW-2:0], 1'b0} + (mg_q[GW-1]  ? {{GW{1'b0}}, mag_q} : '0);
  assign acc_b_next = {acc_b_q[BW-2:0], 1'b0} + (mgc_q[GW-1] ? {{GW{1'b0}}, p1_q}  : '0);

  assign rnd_a = acc_a_q + HALF_A;
  assign rnd_b = acc_b_q + HALF_B;

  // signed correction and saturation
  assign corr    = neg_q ? -$signed({1'b0, rmag_q}) : $signed({1'b0, rmag_q});
  assign est_sum = {{2{est_q[SW-1]}}, est_q} + corr;

  always_comb begin
    if (est_sum > EST_MAX) begin
      est_sat = EST_MAX[SW-1:0];
    end else if (est_sum < EST_MIN) begin
      est_sat = EST_MIN[SW-1:0];
    end else begin
      est_sat = est_sum[SW-1:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q   <= PROCESS_NOISE_RST;
      r_noise_q   <= MEASURE_NOISE_RST;
      cov_q       <= {1'b0, INIT_COV_RST};
      est_q       <= '0;
      gain_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PROCESS_NOISE: q_noise_q <= cfg_data_i;
          CFG_MEASURE_NOISE: r_noise_q <= cfg_data_i;
          // only reset and FIN1 load the covariance, so the write has no effect
          CFG_INIT_COV:      ;
          default:           ;
        endcase
      end

      case (op_i)
        OP_PREP: cnt_q <= CNT_W'(GFB);
        OP_GSET: begin
          cnt_q  <= CNT_W'(GFB);
          gain_q <= g_fix;
        end
        OP_DIV, OP_MUL: if (cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
        OP_FIN1: cov_q <= rnd_b[GFB +: COV_W];
        OP_FIN2: if (out_free) est_q <= est_sat;
        default: ;
      endcase

      if (op_i == OP_FIN2 && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_q <= sample_i;
    end
    case (op_i)
      OP_PREP: begin
        p1_q  <= p1;
        den_q <= den;
        mag_q <= mag;
        neg_q <= diff[SW];
        rem_q <= {{(REM_W-COV_W){1'b0}}, p1};
      end
      OP_DIV: begin
        rem_q <= rem_next;
        quo_q <= {quo_q[GW-2:0], ge};
      end
      OP_GSET: begin
        mg_q    <= g_fix;
        mgc_q   <= GAIN_ONE - g_fix;
        acc_a_q <= '0;
        acc_b_q <= '0;
      end
      OP_MUL: begin
        acc_a_q <= acc_a_next;
        acc_b_q <= acc_b_next;
        mg_q    <= {mg_q[GW-2:0], 1'b0};
        mgc_q   <= {mgc_q[GW-2:0], 1'b0};
      end
      OP_FIN1: rmag_q <= rnd_a[GFB +: DW];
      OP_FIN2: if (out_free) begin
        out_est_q  <= est_sat;
        out_gain_q <= gain_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_used_o = out_gain_q;

endmodule

// ===== rtl/core/scalar_kalman_filter_core.sv =====
// Scalar Kalman filter core (constant-state model), microcoded.
// A result beat is loaded after its sample has passed the PREP, DIV, GSET, MUL, FIN1 and FIN2
// steps; a new sample is taken only back in WAIT, so the sample rate is set by the bit-serial
// divider loop and the bit-serial multiplier loop, each producing GAIN_FRAC_BITS+1 bits.
// Reset (async, active low): noise registers to defaults, covariance to the initial
// covariance default, estimate and gain to zero, sequencer to the wait step.
module scalar_kalman_filter_core #(
  parameter int SAMPLE_WIDTH   = skf_pkg::SKF_SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = skf_pkg::SKF_GAIN_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    estimate_o,
  output logic [GAIN_FRAC_BITS:0]           gain_used_o,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [skf_pkg::REG_W-1:0]         cfg_data_i
);
  import skf_pkg::*;

  // Step program (see ucode_rom):
  //   WAIT  hold until a sample beat lands
  //   PREP  P1 = P + Q, den = P1 + R, split innovation into sign/magnitude
  //   DIV   restoring divide, one gain bit per cycle, GAIN_FRAC_BITS+1 gain bits
  //   GSET  zero-denominator case forces gain 0; gain clamped to 1.0
  //   MUL   |d|*G and P1*(1-G) together, one multiplier bit per cycle
  //   FIN1  round both products; covariance written back
  //   FIN2  correction applied with saturation, result beat loaded once the
  //         output register is free, then back to WAIT
  // The result register decouples the two channels: a finished beat may sit
  // while the next sample is accepted and worked on.

  op_e     op;
  status_t status;

  skf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  skf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .estimate_o  (estimate_o),
    .gain_used_o (gain_used_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

// ===== rtl/core/skf_checker.sv =====
// Port-level assertions for the scalar Kalman filter core, and their bind.
// Depends on scalar_kalman_filter_core ports only.
module skf_checker #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] estimate_o,
  input logic [GAIN_FRAC_BITS:0]        gain_used_o
);

  localparam logic [GAIN_FRAC_BITS:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(estimate_o)
                                    && $stable(gain_used_o))
    else $error("result beat changed while stalled");

  // gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_used_o <= GAIN_ONE)
    else $error("gain above one");

  // a sample beat occupies the sequencer, no back-to-back accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample accepted on consecutive cycles");

  // the result of a sample cannot appear right after the accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind scalar_kalman_filter_core skf_checker #(
  .SAMPLE_WIDTH   (SAMPLE_WIDTH),
  .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_skf_checker (.*);
